[rtl/dhip_pkg.sv]
// ----------------------------------------------------------------------------
// dhip_pkg: shared types and constants for the decimal/hex integer parser
// Character codes, parser phase encoding and digit decode helpers.
// ----------------------------------------------------------------------------
package dhip_pkg;

	localparam logic [7:0] CH_MINUS  = 8'h2D; // '-'
	localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CH_NINE   = 8'h39; // '9'
	localparam logic [7:0] CH_LO_A   = 8'h61; // 'a'
	localparam logic [7:0] CH_LO_F   = 8'h66; // 'f'
	localparam logic [7:0] CH_UP_A   = 8'h41; // 'A'
	localparam logic [7:0] CH_UP_F   = 8'h46; // 'F'
	localparam logic [7:0] CH_LO_X   = 8'h78; // 'x'
	localparam logic [7:0] CH_UP_X   = 8'h58; // 'X'

	// one-hot parse phase
	typedef enum logic [4:0] {
		PH_DONE = 5'b00001,
		PH_LEAD = 5'b00010,
		PH_ZERO = 5'b00100,
		PH_HEX  = 5'b01000,
		PH_DEC  = 5'b10000
	} phase_t;

	// decoded digit: valid flag plus value 0..15
	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} digit_t;

	function automatic digit_t dec_digit(input logic [7:0] c);
		digit_t d;
		d.ok  = (c >= CH_ZERO) && (c <= CH_NINE);
		d.val = c[3:0];
		return d;
	endfunction

	function automatic digit_t hex_digit(input logic [7:0] c);
		digit_t d;
		d.ok  = 1'b0;
		d.val = c[3:0];
		if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
			d.ok = 1'b1;
		end else if (((c >= CH_LO_A) && (c <= CH_LO_F)) ||
			((c >= CH_UP_A) && (c <= CH_UP_F))) begin
			d.ok  = 1'b1;
			d.val = c[3:0] + 4'd9;
		end
		return d;
	endfunction

endpackage

[rtl/decimal_hex_integer_parser.sv]
// ----------------------------------------------------------------------------
// decimal_hex_integer_parser
// Streaming atoi with optional sign and 0x/0X hex prefix, one byte a cycle unless the result is stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (byte_valid / byte_stall): one text character per
//    transaction in text_byte; string_start marks the first byte of a string
//    and restarts the parser, dropping any parse still open.
//  - Output channel (value_valid / value_stall): one transaction per finished
//    parse, carrying the signed value, wrapped modulo 2^VALUE_WIDTH.
//  - A parse finishes on the first byte (sign and x/X prefix apart) that is
//    no digit of the current radix; later bytes are swallowed silently until the next string start.
//  - Path: a byte taken lands in the input register and is decoded there
//    against the parser state; a result it causes is written to the result
//    register and shows on value from there.
//  - Throughput: one byte per cycle unless value_stall holds a pending result.
//    The per-byte work (digit decode, accumulate by x10 or x16 as shift-add)
//    sits between the input register and the parser state/result registers.
//  - Stall: while value_stall holds a pending result, the input register keeps
//    its byte and byte_stall rises; nothing is lost or repeated.
//  - Reset (arst_n low): parser returns to the idle done phase, both channels
//    empty.
// ----------------------------------------------------------------------------
module decimal_hex_integer_parser #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// byte channel
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    text_byte,
	input  logic                          string_start,
	// result channel
	output logic                          value_valid,
	input  logic                          value_stall,
	output logic signed [VALUE_WIDTH-1:0] value
);

	// input register
	logic             v_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;

	// parser state
	dhip_pkg::phase_t         phase_q;
	logic                     neg_q;
	logic [VALUE_WIDTH-1:0]   acc_q;

	// result register
	logic                     out_v_q;
	logic [VALUE_WIDTH-1:0]   out_q;

	// decode of the byte in s1
	logic                     adv;
	dhip_pkg::phase_t         ph_eff;
	logic                     neg_eff;
	logic [VALUE_WIDTH-1:0]   acc_eff;
	dhip_pkg::phase_t         ph_nxt;
	logic                     neg_nxt;
	logic [VALUE_WIDTH-1:0]   acc_nxt;
	logic                     fin;
	logic [VALUE_WIDTH-1:0]   res;
	dhip_pkg::digit_t         dd;
	dhip_pkg::digit_t         hd;
	logic [VALUE_WIDTH-1:0]   acc_x10;
	logic [VALUE_WIDTH-1:0]   acc_x16;

	// s1 moves on when the result register is free or being drained
	assign adv        = v_s1 && (!out_v_q || !value_stall);
	assign byte_stall = v_s1 && !adv;

	assign dd      = dhip_pkg::dec_digit(byte_s1);
	assign hd      = dhip_pkg::hex_digit(byte_s1);
	assign acc_x10 = (acc_eff << 3) + (acc_eff << 1) + VALUE_WIDTH'(dd.val);
	assign acc_x16 = (acc_eff << 4) + VALUE_WIDTH'(hd.val);

	// a start byte resets sign and accumulator, then is parsed in LEAD
	assign ph_eff  = start_s1 ? dhip_pkg::PH_LEAD : phase_q;
	assign neg_eff = start_s1 ? 1'b0 : neg_q;
	assign acc_eff = start_s1 ? '0 : acc_q;

	always_comb begin
		ph_nxt  = ph_eff;
		neg_nxt = neg_eff;
		acc_nxt = acc_eff;
		fin     = 1'b0;
		if (start_s1 && (byte_s1 == dhip_pkg::CH_MINUS)) begin
			neg_nxt = 1'b1;
			ph_nxt  = dhip_pkg::PH_LEAD;
		end else begin
			case (ph_eff)
				dhip_pkg::PH_LEAD: begin
					if (byte_s1 == dhip_pkg::CH_ZERO) begin
						acc_nxt = '0;
						ph_nxt  = dhip_pkg::PH_ZERO;
					end else if (dd.ok) begin
						acc_nxt = VALUE_WIDTH'(dd.val);
						ph_nxt  = dhip_pkg::PH_DEC;
					end else begin
						fin = 1'b1;
					end
				end
				dhip_pkg::PH_ZERO: begin
					if ((byte_s1 == dhip_pkg::CH_LO_X) || (byte_s1 == dhip_pkg::CH_UP_X)) begin
						ph_nxt = dhip_pkg::PH_HEX;
					end else if (dd.ok) begin
						acc_nxt = acc_x10;
						ph_nxt  = dhip_pkg::PH_DEC;
					end else begin
						fin = 1'b1;
					end
				end
				dhip_pkg::PH_DEC: begin
					if (dd.ok) begin
						acc_nxt = acc_x10;
					end else begin
						fin = 1'b1;
					end
				end
				dhip_pkg::PH_HEX: begin
					if (hd.ok) begin
						acc_nxt = acc_x16;
					end else begin
						fin = 1'b1;
					end
				end
				default: begin
					// done or stray code: ignore the byte
					ph_nxt = dhip_pkg::PH_DONE;
				end
			endcase
			if (fin) begin
				ph_nxt = dhip_pkg::PH_DONE;
			end
		end
	end

	// two's complement negation wraps naturally at VALUE_WIDTH
	assign res = neg_eff ? (~acc_eff + VALUE_WIDTH'(1)) : acc_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!byte_stall) begin
			v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= text_byte;
			start_s1 <= string_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dhip_pkg::PH_DONE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (adv) begin
			phase_q <= ph_nxt;
			neg_q   <= neg_nxt;
			acc_q   <= acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && fin) begin
			out_v_q <= 1'b1;
		end else if (!value_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin) begin
			out_q <= res;
		end
	end

	assign value_valid = out_v_q;
	assign value       = out_q;

	// ---- assertions ----
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (v_s1 && out_v_q && value_stall))
		else $error("byte_stall raised without a blocked result");

	a_finish_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fin) |=> (phase_q == dhip_pkg::PH_DONE) && value_valid)
		else $error("finished parse did not leave done phase and a result");

	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> v_s1 && $stable(byte_s1) && $stable(start_s1))
		else $error("stalled input register changed");

	a_start_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && start_s1 && (byte_s1 != dhip_pkg::CH_MINUS)) |=> !neg_q)
		else $error("sign set by a start byte that is not a minus");

endmodule

[tb/sv/dhip_checker.sv]
// ----------------------------------------------------------------------------
// dhip_checker: scoreboard for the decimal/hex integer parser
// Follows the byte channel with its own parser model and compares every
// value transaction with the oldest value that model still owes.
// ----------------------------------------------------------------------------
module dhip_checker #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                byte_stall,
	input  logic [7:0]          text_byte,
	input  logic                string_start,
	input  logic                value_valid,
	input  logic                value_stall,
	input  logic signed [W-1:0] value,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	dhip_pkg::phase_t    parse_phase;
	logic                neg_sign;
	logic [W-1:0]        acc;
	logic signed [W-1:0] owed_values[$];

	// digit weight of c in the given radix, -1 if c is no digit of it
	function automatic int digit_of(input logic [7:0] c, input bit hex);
		if (c >= dhip_pkg::CH_ZERO && c <= dhip_pkg::CH_NINE)
			return int'(c - dhip_pkg::CH_ZERO);
		if (hex && c >= dhip_pkg::CH_LO_A && c <= dhip_pkg::CH_LO_F)
			return int'(c - dhip_pkg::CH_LO_A) + 10;
		if (hex && c >= dhip_pkg::CH_UP_A && c <= dhip_pkg::CH_UP_F)
			return int'(c - dhip_pkg::CH_UP_A) + 10;
		return -1;
	endfunction

	task automatic parse_byte(input logic [7:0] c, input logic first,
			output bit emit, output logic signed [W-1:0] v);
		bit take_digit;
		bit hex;
		int d;
		emit       = 1'b0;
		v          = '0;
		take_digit = 1'b0;
		hex        = 1'b0;
		if (first) begin
			neg_sign    = 1'b0;
			acc         = '0;
			parse_phase = dhip_pkg::PH_LEAD;
			if (c == dhip_pkg::CH_MINUS) begin
				neg_sign = 1'b1;
				return;
			end
		end
		case (parse_phase)
			dhip_pkg::PH_LEAD: begin
				// accumulator is still zero here, so a first digit just lands
				if (c == dhip_pkg::CH_ZERO)
					parse_phase = dhip_pkg::PH_ZERO;
				else
					take_digit = 1'b1;
			end
			dhip_pkg::PH_ZERO: begin
				if (c == dhip_pkg::CH_LO_X || c == dhip_pkg::CH_UP_X)
					parse_phase = dhip_pkg::PH_HEX;
				else
					take_digit = 1'b1;
			end
			dhip_pkg::PH_DEC: take_digit = 1'b1;
			dhip_pkg::PH_HEX: begin
				take_digit = 1'b1;
				hex        = 1'b1;
			end
			default: parse_phase = dhip_pkg::PH_DONE;
		endcase
		if (take_digit) begin
			d = digit_of(c, hex);
			if (d < 0) begin
				emit        = 1'b1;
				v           = neg_sign ? -acc : acc;
				parse_phase = dhip_pkg::PH_DONE;
			end else begin
				acc = acc * (hex ? W'(16) : W'(10)) + W'(d);
				if (!hex)
					parse_phase = dhip_pkg::PH_DEC;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit                  emit;
		logic signed [W-1:0] v;
		if (!arst_n) begin
			parse_phase  = dhip_pkg::PH_DONE;
			neg_sign     = 1'b0;
			acc          = '0;
			owed_values.delete();
			fail_count   = 0;
			results_seen = 0;
		end else begin
			// results first: a byte taken on this edge cannot be answered yet
			if (value_valid && !value_stall) begin
				results_seen++;
				if (owed_values.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected value transaction: expected none, got %0d",
						$time, value);
				end else begin
					v = owed_values.pop_front();
					if (value !== v) begin
						fail_count++;
						$display("%0t: value mismatch: expected %0d (0x%h), got %0d (0x%h)",
							$time, v, v, value, value);
					end
				end
			end
			if (byte_valid && !byte_stall) begin
				parse_byte(text_byte, string_start, emit, v);
				if (emit)
					owed_values.push_back(v);
			end
		end
		pending = owed_values.size();
	end

endmodule

[tb/sv/tb_decimal_hex_integer_parser.sv]
// ----------------------------------------------------------------------------
// tb_decimal_hex_integer_parser: testbench top for the streaming integer parser
// Feeds directed strings, then random well-formed numbers with noise, under
// random idling on both channels; dhip_checker scores the value stream.
// ----------------------------------------------------------------------------
module tb_decimal_hex_integer_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW      = 32;
	localparam int N_ITEMS = 750;
	// tail of the run with both channels kept busy
	localparam int QUIET_TAIL = 120;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 byte_valid   = 1'b0;
	logic                 byte_stall;
	logic [7:0]           text_byte    = 8'h00;
	logic                 string_start = 1'b0;
	logic                 value_valid;
	logic                 value_stall  = 1'b0;
	logic signed [VW-1:0] value;

	int fail_count;
	int pending;
	int results_seen;
	int items_sent   = 0;
	int strings_sent = 0;
	bit idle_on      = 1'b1;

	always #5 clk = ~clk;

	decimal_hex_integer_parser #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.text_byte    (text_byte),
		.string_start (string_start),
		.value_valid  (value_valid),
		.value_stall  (value_stall),
		.value        (value)
	);

	dhip_checker #(
		.W(VW)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.text_byte    (text_byte),
		.string_start (string_start),
		.value_valid  (value_valid),
		.value_stall  (value_stall),
		.value        (value),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// used only to pick terminators that really end the number
	function automatic bit is_digit_of(input logic [7:0] c, input bit hex);
		return (c >= dhip_pkg::CH_ZERO && c <= dhip_pkg::CH_NINE) ||
			(hex && ((c >= dhip_pkg::CH_LO_A && c <= dhip_pkg::CH_LO_F) ||
			(c >= dhip_pkg::CH_UP_A && c <= dhip_pkg::CH_UP_F)));
	endfunction

	// hex digit, with the groups 0-9, a-f and A-F equally likely
	function automatic logic [7:0] rand_hex_char();
		case ($urandom_range(0, 2))
			0:       return 8'(dhip_pkg::CH_ZERO + $urandom_range(0, 9));
			1:       return 8'(dhip_pkg::CH_LO_A + $urandom_range(0, 5));
			default: return 8'(dhip_pkg::CH_UP_A + $urandom_range(0, 5));
		endcase
	endfunction

	// One byte transaction. Valid may drop for a burst beforehand; data stays
	// put while stalled. Returns on the edge that takes the byte.
	task automatic send_byte(input logic [7:0] c, input bit first, input bit counted);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		byte_valid   <= 1'b1;
		text_byte    <= c;
		string_start <= first;
		do @(posedge clk); while (byte_stall);
		if (counted)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == 0, 1'b1);
	endtask

	// Mostly well-formed numbers: optional sign, decimal or 0x/0X hex, a
	// random digit count (now and then long enough to wrap), then a byte that
	// ends the parse. Some strings lack the terminator and get cut off by the
	// next start; some carry junk after the end; a tenth are pure noise.
	task automatic send_random_string();
		logic [7:0] txt[$];
		logic [7:0] t;
		int         mode;
		int         n_dig;
		bit         hex;
		bit         st;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			repeat ($urandom_range(1, 4)) begin
				st = ($urandom_range(0, 3) == 0);
				send_byte(8'($urandom_range(0, 255)), st, st);
			end
			return;
		end
		if ($urandom_range(0, 1))
			txt.push_back(dhip_pkg::CH_MINUS);
		hex   = (mode <= 3);
		n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
		if (hex) begin
			txt.push_back(dhip_pkg::CH_ZERO);
			txt.push_back($urandom_range(0, 1) ? dhip_pkg::CH_LO_X : dhip_pkg::CH_UP_X);
			repeat (n_dig) txt.push_back(rand_hex_char());
		end else begin
			// leading zero that turns out not to be a hex prefix
			if (mode == 4)
				txt.push_back(dhip_pkg::CH_ZERO);
			repeat (n_dig) txt.push_back(8'(dhip_pkg::CH_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 6) != 0 || txt.size() == 0) begin
			do t = 8'($urandom_range(0, 255)); while (is_digit_of(t, hex));
			txt.push_back(t);
		end
		foreach (txt[i])
			send_byte(txt[i], i == 0, 1'b1);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		strings_sent++;
	endtask

	// Result side back-pressure: stall bursts between free-running stretches;
	// switched off for the quiet tail.
	initial begin
		wait (arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				value_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				value_stall <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		send_byte(8'hFF, 1'b1, 1'b1);     // top byte value, no digits at all
		send_byte(8'h00, 1'b1, 1'b1);     // bottom byte value, no digits
		send_text("-9");
		send_byte(8'h00, 1'b0, 1'b1);     // negative single digit
		send_text("- ");                  // sign only gives zero
		send_text("0xg");                 // hex prefix with no hex digit
		send_text("05/");                 // leading zero stays decimal
		send_text("0XfF:");               // upper-case prefix, mixed-case digits
		send_text("1");                   // open parse ...
		send_text("2 ");                  // ... dropped by a fresh start
		send_byte("A", 1'b0, 1'b1);       // byte after the end is swallowed

		// --- random part; the tail runs without idling ---
		while (items_sent < N_ITEMS) begin
			if (items_sent > N_ITEMS - QUIET_TAIL)
				idle_on = 1'b0;
			send_random_string();
		end
		byte_valid <= 1'b0;

		// drain, then leave room for any stray transaction
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);

		$display("Run: %0d random strings plus directed cases, %0d bytes, %0d values checked.",
			strings_sent, items_sent, results_seen);
		$display("Covered sign, both hex prefixes, leading zero, wrap-around, dropped parses.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Timeout with %0d values outstanding", pending);
		$display("Verification failed");
		$finish;
	end

endmodule
